// ===== rtl/mlfd_pkg.sv =====
// Shared types, constants and the magic-hunt step for the magic/length frame deframer.
`default_nettype none

package mlfd_pkg;

    localparam int          MAGIC_LEN_INT   = 5;
    localparam logic [2:0]  MAGIC_LEN       = 3'(MAGIC_LEN_INT);
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

    // One result item: payload byte, last flag, announced frame length.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic [31:0] frame_length;
    } t_payload;

    typedef struct packed {
        logic     valid;
        t_payload data;
    } t_result;

    // Expected character of the magic "FRAME" at a given match position.
    function automatic logic [7:0] magic_char(logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h46; // F
            3'd1:    c = 8'h52; // R
            3'd2:    c = 8'h41; // A
            3'd3:    c = 8'h4D; // M
            3'd4:    c = 8'h45; // E
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Advance the match count by one byte; a mismatch on 'F' restarts at one.
    function automatic logic [2:0] hunt_advance(logic [2:0] m, logic [7:0] b);
        logic [2:0] r;
        if ((m < MAGIC_LEN) && (b == magic_char(m))) begin
            r = m + 3'd1;
        end else if (b == magic_char(3'd0)) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mlfd_core.sv =====
// Deframer state machine: magic hunt, length collection and payload pass-through.
`default_nettype none

module mlfd_core #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [31:0]      i_cfg_wr_data,
    output mlfd_pkg::t_result     o_result
);

    localparam int LBW      = (LENGTH_FIELD_BYTES > 1) ? $clog2(LENGTH_FIELD_BYTES) : 1;
    localparam int SHIFT_W  = 8 * LENGTH_FIELD_BYTES;
    localparam logic [LBW-1:0] LAST_POS = LBW'(LENGTH_FIELD_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } t_phase;

    t_phase             r_phase,  n_phase;
    logic [2:0]         r_match,  n_match;
    logic [LBW-1:0]     r_cnt,    n_cnt;
    logic [SHIFT_W-1:0] r_shift,  n_shift;
    logic [31:0]        r_ann,    n_ann;
    logic [31:0]        r_rem,    n_rem;
    logic [31:0]        r_max;

    always_comb begin
        logic [31:0] len;
        logic [2:0]  m;
        n_phase  = r_phase;
        n_match  = r_match;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_ann    = r_ann;
        n_rem    = r_rem;
        len      = 32'(r_shift);
        m        = 3'd0;
        o_result = '0;
        if (i_valid) begin
            case (r_phase)
                PH_LEN: begin
                    n_shift[r_cnt*8 +: 8] = i_byte;
                    if (r_cnt == LAST_POS) begin
                        n_cnt = '0;
                        len   = 32'(n_shift);
                        if ((len == 32'd0) || (len > r_max)) begin
                            // rescan the rejected length bytes for a partial magic
                            n_phase = PH_HUNT;
                            m       = 3'd0;
                            for (int i = 0; i < LENGTH_FIELD_BYTES; i++) begin
                                m = mlfd_pkg::hunt_advance(m, n_shift[i*8 +: 8]);
                            end
                            n_match = m;
                        end else begin
                            n_ann   = len;
                            n_rem   = len;
                            n_phase = PH_PAY;
                        end
                    end else begin
                        n_cnt = r_cnt + LBW'(1);
                    end
                end
                PH_PAY: begin
                    n_rem                       = r_rem - 32'd1;
                    o_result.valid              = 1'b1;
                    o_result.data.payload_byte  = i_byte;
                    o_result.data.last_byte     = (n_rem == 32'd0);
                    o_result.data.frame_length  = r_ann;
                    if (n_rem == 32'd0) begin
                        n_phase = PH_HUNT;
                        n_match = 3'd0;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    m       = mlfd_pkg::hunt_advance(r_match, i_byte);
                    if (m == mlfd_pkg::MAGIC_LEN) begin
                        n_match = 3'd0;
                        n_cnt   = '0;
                        n_shift = '0;
                        n_phase = PH_LEN;
                    end else begin
                        n_match = m;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_match <= 3'd0;
            r_cnt   <= '0;
            r_shift <= '0;
            r_ann   <= 32'd0;
            r_rem   <= 32'd0;
            r_max   <= mlfd_pkg::MAX_PAYLOAD_RST;
        end else begin
            r_phase <= n_phase;
            r_match <= n_match;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_ann   <= n_ann;
            r_rem   <= n_rem;
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mlfd_skid.sv =====
// Output register with one skid stage for the result stream.
`default_nettype none

module mlfd_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire mlfd_pkg::t_payload i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    output mlfd_pkg::t_payload      o_data,
    input  wire logic               i_ready
);

    logic               r_out_v;
    logic               r_skid_v;
    mlfd_pkg::t_payload r_out;
    mlfd_pkg::t_payload r_skid;
    logic               out_take;

    assign out_take = r_out_v && i_ready;
    assign o_ready  = !r_skid_v;
    assign o_valid  = r_out_v;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // drain the skid stage once the output request is taken
            if (out_take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_v || out_take) begin
                r_out   <= i_data;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= i_data;
                r_skid_v <= 1'b1;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/magic_length_frame_deframer.sv =====
// Top level of the magic/length frame deframer: byte stream in, payload stream out.
// Takes one received byte per cycle while o_s_tready is high and hunts for the ASCII magic
// "FRAME", then collects a LENGTH_FIELD_BYTES little-endian payload length and passes that
// many bytes out, one request per byte, with tlast on the final byte and the announced length
// beside it. A zero length or one above the max_payload_length register drops the header and
// rescans the length bytes for a partial magic. Every byte is handled in the cycle it is
// accepted, so the block sustains one byte per cycle while the output is not stalled; results
// go through an output register and a one-entry skid stage, and o_s_tready drops only while
// that skid stage holds a request. Configure the register only while idle.
`default_nettype none

module magic_length_frame_deframer #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,   // max_payload_length
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,       // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,       // [7:0] payload_byte, [39:8] frame_length
    output logic             o_m_tlast        // last_byte
);

    mlfd_pkg::t_result  w_res;
    mlfd_pkg::t_payload w_out;
    logic               w_accept;

    assign w_accept = i_s_tvalid && o_s_tready;

    mlfd_core #(
        .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_accept),
        .i_byte        (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (w_res)
    );

    mlfd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res.valid),
        .i_data  (w_res.data),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {w_out.frame_length, w_out.payload_byte};
    assign o_m_tlast = w_out.last_byte;

    // a full skid stage implies the output register also holds a request
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("skid stage full while output register empty");

    // the input stalls only after an output request went untaken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> $past(o_m_tvalid) && !$past(i_m_tready))
        else $error("input stalled without output backpressure");

    // an accepted frame never announces a zero length
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (w_res.data.frame_length != 32'd0))
        else $error("payload byte with zero frame length");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the magic/length frame deframer: byte stream in, checked payload stream out.
`default_nettype none

module testbench;

    localparam int          LENGTH_FIELD_BYTES = 4;
    localparam int          MAGIC_CHARS        = 5;
    localparam logic [39:0] MAGIC_WORD         = "FRAME";
    localparam logic [31:0] MAX_LEN_RESET      = 32'd1048576;
    localparam int          SETTLE_CYCLES      = 8;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_LENGTH,
        ST_PAYLOAD
    } t_rx_phase;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_s_tvalid    = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata     = '0;
    logic        o_m_tvalid;
    logic        i_m_tready    = 1'b0;
    logic [39:0] o_m_tdata;    // [7:0] payload_byte, [39:8] frame_length
    logic        o_m_tlast;    // last_byte

    // Payload model state
    t_rx_phase   rx_phase      = ST_HUNT;
    logic [2:0]  magic_count   = '0;
    logic [1:0]  len_bytes_seen = '0;
    logic [31:0] len_accum     = '0;
    logic [31:0] frame_len     = '0;
    logic [31:0] bytes_left    = '0;
    logic [31:0] max_len       = MAX_LEN_RESET;

    mlfd_pkg::t_payload expected_payload_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_items    = 0;
    int error_count   = 0;

    magic_length_frame_deframer #(
        .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] magic_at(input int idx);
        return MAGIC_WORD[8 * (MAGIC_CHARS - 1 - idx) +: 8];
    endfunction

    function automatic logic [2:0] next_magic_count(input logic [2:0] m, input logic [7:0] b);
        if ((m < MAGIC_CHARS) && (b == magic_at(int'(m)))) begin
            return m + 3'd1;
        end
        return (b == magic_at(0)) ? 3'd1 : 3'd0;
    endfunction

    task automatic hunt_magic(input logic [7:0] b);
        logic [2:0] m;
        m = next_magic_count(magic_count, b);
        if (m == MAGIC_CHARS) begin
            rx_phase       = ST_LENGTH;
            magic_count    = '0;
            len_bytes_seen = '0;
            len_accum      = '0;
        end else begin
            magic_count = m;
        end
    endtask

    // Advance the payload model by one accepted byte and queue any payload request it causes.
    task automatic track_rx_byte(input logic [7:0] b);
        mlfd_pkg::t_payload exp_item;
        logic [31:0]        rejected;
        case (rx_phase)
            ST_LENGTH: begin
                len_accum = len_accum | ({24'd0, b} << (8 * len_bytes_seen));
                if (len_bytes_seen == LENGTH_FIELD_BYTES - 1) begin
                    len_bytes_seen = '0;
                    if ((len_accum == 0) || (len_accum > max_len)) begin
                        // rescan the length bytes for a partial magic
                        rx_phase    = ST_HUNT;
                        magic_count = '0;
                        rejected    = len_accum;
                        for (int i = 0; i < LENGTH_FIELD_BYTES; i++) begin
                            hunt_magic(rejected[8 * i +: 8]);
                        end
                    end else begin
                        frame_len  = len_accum;
                        bytes_left = len_accum;
                        rx_phase   = ST_PAYLOAD;
                    end
                end else begin
                    len_bytes_seen = len_bytes_seen + 2'd1;
                end
            end
            ST_PAYLOAD: begin
                bytes_left            = bytes_left - 32'd1;
                exp_item.payload_byte = b;
                exp_item.last_byte    = (bytes_left == 0);
                exp_item.frame_length = frame_len;
                expected_payload_q.push_back(exp_item);
                if (bytes_left == 0) begin
                    rx_phase    = ST_HUNT;
                    magic_count = '0;
                end
            end
            default: begin
                rx_phase = ST_HUNT;
                hunt_magic(b);
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] rx);
        // idle the sender in the given share of cycles
        while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rx;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        track_rx_byte(rx);
        sent_items++;
    endtask

    task automatic send_header(input logic [31:0] len);
        for (int i = 0; i < MAGIC_CHARS; i++) send_byte(magic_at(i));
        for (int i = 0; i < LENGTH_FIELD_BYTES; i++) send_byte(len[8 * i +: 8]);
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    // Noise never carries the closing magic character, so it cannot open a frame.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        if ($urandom_range(1) == 0) begin
            b = magic_at($urandom_range(MAGIC_CHARS - 2));
        end else begin
            b = 8'($urandom_range(255));
        end
        return (b == magic_at(MAGIC_CHARS - 1)) ? 8'h65 : b;
    endfunction

    // Hold the sender until every queued payload request has come out.
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        wait (expected_payload_q.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        max_len = value;
    endtask

    task automatic test_directed();
        write_max_length(MAX_LEN_RESET);
        send_byte(8'h00);
        // overlapping magic, shortest frame
        send_byte(magic_at(0));
        send_header(32'd1);
        send_byte(8'hFF);
        // over-long length holding a partial magic, completed by the next bytes
        send_header({magic_at(2), magic_at(1), magic_at(0), 8'h5A});
        send_byte(magic_at(3));
        send_byte(magic_at(4));
        // zero length
        repeat (LENGTH_FIELD_BYTES) send_byte(8'h00);
    endtask

    task automatic test_max_extremes();
        write_max_length(32'd0);
        send_header(32'd1);
        write_max_length(32'd1);
        send_header(32'd1);
        send_payload(1);
        send_header(32'd2);
    endtask

    task automatic test_random(input int target, input int snd_pct, input int rcv_pct,
                               input logic [31:0] max_value);
        int          start;
        int          pick;
        int          len_hi;
        logic [31:0] len;
        write_max_length(max_value);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = sent_items;
        while (sent_items - start < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len_hi = (max_len < 16) ? int'(max_len) : 16;
                len    = $urandom_range(len_hi, 1);
                send_header(len);
                send_payload(int'(len));
            end else if (pick < 80 && max_len != 32'hFFFF_FFFF) begin
                case ($urandom_range(2))
                    0:       len = 32'd0;
                    1:       len = max_len + 32'd1;
                    default: len = {noise_byte(), noise_byte(), noise_byte(), noise_byte()};
                endcase
                if (len != 0 && len <= max_len) len = 32'd0;
                send_header(len);
            end else if (pick < 97) begin
                for (int i = $urandom_range(MAGIC_CHARS - 1); i > 0; i--) begin
                    send_byte(magic_at(MAGIC_CHARS - 1 - i));
                end
                repeat ($urandom_range(1, 3)) send_byte(noise_byte());
            end else begin
                hold_until_drained();
            end
        end
    endtask

    // Largest possible length: the frame never ends, but every early byte comes out.
    task automatic test_longest_frame();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max_length(32'hFFFF_FFFF);
        send_header(32'hFFFF_FFFF);
        send_payload(20);
    endtask

    always @(posedge i_clk) begin : check_payload
        mlfd_pkg::t_payload want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_payload_q.size() == 0) begin
                $display("%0t: unexpected payload request: byte %02h last %0b length %08h",
                         $time, o_m_tdata[7:0], o_m_tlast, o_m_tdata[39:8]);
                error_count++;
            end else begin
                want = expected_payload_q.pop_front();
                if (o_m_tdata[7:0] !== want.payload_byte) begin
                    $display("%0t: payload_byte mismatch: expected %02h, actual %02h",
                             $time, want.payload_byte, o_m_tdata[7:0]);
                    error_count++;
                end
                if (o_m_tlast !== want.last_byte) begin
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, want.last_byte, o_m_tlast);
                    error_count++;
                end
                if (o_m_tdata[39:8] !== want.frame_length) begin
                    $display("%0t: frame_length mismatch: expected %08h, actual %08h",
                             $time, want.frame_length, o_m_tdata[39:8]);
                    error_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_max_extremes();
        test_random(540, 26, 88, MAX_LEN_RESET);
        test_random(540, 88, 26, 32'($urandom_range(20, 1)));
        test_random(540, 0, 0, 32'($urandom_range(32'hFFFF_FFFE, 1)));
        test_longest_frame();
        hold_until_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/mlfd_pkg.sv
rtl/mlfd_core.sv
rtl/mlfd_skid.sv
rtl/magic_length_frame_deframer.sv
test/testbench.sv
